// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/tnp_pkg.sv -----
package tnp_pkg;

  localparam int CoordW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int SumW      = ProdW + 1;
  localparam int CrossW    = SumW + 2;
  localparam int Len2W     = ProdW;
  localparam int AccW      = Len2W + 1;
  localparam int MagW      = CoordW;
  localparam int NumVtx    = 3;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int DivLat    = MagW + 1;
  localparam int StgA4     = 3;
  localparam int StgR      = StgA4 + DivLat;
  localparam int NumStages = StgR + 8;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic [Len2W-1:0]         len2_t;
  typedef logic [MagW-1:0]          mag_t;

  typedef enum logic [2:0] {
    REG_V0X, REG_V0Y, REG_V1X, REG_V1Y, REG_V2X, REG_V2Y
  } reg_idx_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cand_t;

  typedef struct packed {
    cand_t pt;
    len2_t d;
  } best_t;

  typedef struct packed {
    cand_t             q;
    logic              in_tri;
    logic [NumVtx-1:0] skip;
    logic [NumVtx-1:0] lo;
    logic [NumVtx-1:0] hi;
    len2_t             dv0;
  } side_t;

  function automatic best_t pick_best(best_t cur, cand_t c, len2_t d, logic skip);
    best_t res;
    res = cur;
    if (!skip && (d < cur.d)) begin
      res.pt = c;
      res.d  = d;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/tnp_div.sv -----
module tnp_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  tnp_pkg::len2_t num_i,
  input  tnp_pkg::len2_t den_i,
  input  tnp_pkg::mag_t  mag_i,
  output tnp_pkg::mag_t  quot_o
);

  // round(mag * num / den), num < den, one multiplier bit per stage
  tnp_pkg::len2_t rem_q [tnp_pkg::MagW];
  tnp_pkg::len2_t num_q [tnp_pkg::MagW];
  tnp_pkg::mag_t  quo_q [tnp_pkg::MagW];
  tnp_pkg::mag_t  res_q;
  logic           up;

  for (genvar s = 0; s < tnp_pkg::MagW; s++) begin : g_step
    tnp_pkg::len2_t          rem_p;
    tnp_pkg::len2_t          num_p;
    tnp_pkg::mag_t           quo_p;
    logic [tnp_pkg::AccW-1:0] acc;
    logic [tnp_pkg::AccW-1:0] rem_w;
    logic [1:0]              dig;

    if (s == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign num_p = num_q[s-1];
      assign quo_p = quo_q[s-1];
    end

    always_comb begin
      acc = {rem_p, 1'b0} + (mag_i[tnp_pkg::MagW-1-s] ? {1'b0, num_p} : '0);
      priority if (acc >= {den_i, 1'b0}) begin
        dig   = 2'd2;
        rem_w = acc - {den_i, 1'b0};
      end else if (acc >= {1'b0, den_i}) begin
        dig   = 2'd1;
        rem_w = acc - {1'b0, den_i};
      end else begin
        dig   = 2'd0;
        rem_w = acc;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_w[tnp_pkg::Len2W-1:0];
        num_q[s] <= num_p;
        quo_q[s] <= {quo_p[tnp_pkg::MagW-2:0], 1'b0} + tnp_pkg::mag_t'(dig);
      end
    end
  end

  assign up = {rem_q[tnp_pkg::MagW-1], 1'b0} >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= quo_q[tnp_pkg::MagW-1] + tnp_pkg::mag_t'(up);
    end
  end

  assign quot_o = res_q;

endmodule

// ----- rtl/core/triangle_nearest_point.sv -----
// Throughput: one request per cycle; the edge dividers take one quotient bit per
// stage, which sets the depth. A stall on the master side holds the whole pipe.
// Reset: vertex registers clear to zero, all pipeline valid bits clear.
// Vertex writes reach dx/dy, then the products and magnitudes, then len2 and c.
`include "assert_macros.svh"

module triangle_nearest_point (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tnp_pkg::AddrW-1:0]   paddr,
  input  logic [tnp_pkg::DataW-1:0]   pwdata,
  output logic [tnp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // query_x, query_y
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // nearest_x, nearest_y
  output logic [0:0]                  m_tuser    // was_inside
);

  localparam int NV = tnp_pkg::NumVtx;

  tnp_pkg::coord_t   vx_q [NV];
  tnp_pkg::coord_t   vy_q [NV];
  tnp_pkg::reg_idx_e idx;
  logic              wr;

  tnp_pkg::diff_t    dx_q [NV];
  tnp_pkg::diff_t    dy_q [NV];
  tnp_pkg::mag_t     magx_q [NV];
  tnp_pkg::mag_t     magy_q [NV];
  tnp_pkg::prod_t    lx_q [NV];
  tnp_pkg::prod_t    ly_q [NV];
  tnp_pkg::len2_t    len2_q [NV];
  tnp_pkg::prod_t    cp1_q, cp2_q;
  tnp_pkg::sum_t     c_q;

  logic                          en;
  logic [tnp_pkg::NumStages-1:0] vld_q;
  tnp_pkg::cand_t                q_in;

  tnp_pkg::cand_t    q1_q, q2_q, q3_q;
  tnp_pkg::diff_t    w1x_q [NV];
  tnp_pkg::diff_t    w1y_q [NV];
  tnp_pkg::prod_t    ap1_q, ap2_q, bp1_q, bp2_q, vx2_q, vy2_q;
  tnp_pkg::prod_t    kx_q [NV];
  tnp_pkg::prod_t    ky_q [NV];
  tnp_pkg::sum_t     a3_q, b3_q;
  tnp_pkg::sum_t     k3_q [NV];
  tnp_pkg::len2_t    dv3_q;

  tnp_pkg::cross_t   rr;
  tnp_pkg::sum_t     len2s [NV];
  tnp_pkg::side_t    side4_d, side4_q;
  tnp_pkg::len2_t    kdiv_d [NV];
  tnp_pkg::len2_t    kdiv_q [NV];
  tnp_pkg::side_t    side_dl_q [tnp_pkg::DivLat];
  tnp_pkg::mag_t     quotx [NV];
  tnp_pkg::mag_t     quoty [NV];

  tnp_pkg::side_t    side_r;
  tnp_pkg::cand_t    cand_r [NV];
  tnp_pkg::diff_t    offx, offy;
  logic [NV-1:0]     quot_ok;

  tnp_pkg::side_t    side_p_q [7];
  tnp_pkg::cand_t    cand_q [7][NV];
  tnp_pkg::diff_t    ex_q [NV];
  tnp_pkg::diff_t    ey_q [NV];
  tnp_pkg::prod_t    sx_q [NV];
  tnp_pkg::prod_t    sy_q [NV];
  tnp_pkg::len2_t    dd_q [3][NV];
  tnp_pkg::best_t    best_q [3];
  tnp_pkg::best_t    best_init;

  logic              m_valid_q;
  tnp_pkg::cand_t    out_q;
  logic              out_in_q;

  // configuration port
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = tnp_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (wr) begin
      unique case (idx)
        tnp_pkg::REG_V0X: vx_q[0] <= pwdata[tnp_pkg::CoordW-1:0];
        tnp_pkg::REG_V0Y: vy_q[0] <= pwdata[tnp_pkg::CoordW-1:0];
        tnp_pkg::REG_V1X: vx_q[1] <= pwdata[tnp_pkg::CoordW-1:0];
        tnp_pkg::REG_V1Y: vy_q[1] <= pwdata[tnp_pkg::CoordW-1:0];
        tnp_pkg::REG_V2X: vx_q[2] <= pwdata[tnp_pkg::CoordW-1:0];
        tnp_pkg::REG_V2Y: vy_q[2] <= pwdata[tnp_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      tnp_pkg::REG_V0X: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vx_q[0]};
      tnp_pkg::REG_V0Y: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vy_q[0]};
      tnp_pkg::REG_V1X: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vx_q[1]};
      tnp_pkg::REG_V1Y: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vy_q[1]};
      tnp_pkg::REG_V2X: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vx_q[2]};
      tnp_pkg::REG_V2Y: prdata = {{(tnp_pkg::DataW-tnp_pkg::CoordW){1'b0}}, vy_q[2]};
      default: prdata = '0;
    endcase
  end

  // edge terms that follow the vertex registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NV; i++) begin
      dx_q[i]   <= tnp_pkg::diff_t'(vx_q[(i == NV-1) ? 0 : i+1]) - tnp_pkg::diff_t'(vx_q[i]);
      dy_q[i]   <= tnp_pkg::diff_t'(vy_q[(i == NV-1) ? 0 : i+1]) - tnp_pkg::diff_t'(vy_q[i]);
      magx_q[i] <= dx_q[i][tnp_pkg::DiffW-1] ? tnp_pkg::mag_t'(-dx_q[i])
                                             : tnp_pkg::mag_t'(dx_q[i]);
      magy_q[i] <= dy_q[i][tnp_pkg::DiffW-1] ? tnp_pkg::mag_t'(-dy_q[i])
                                             : tnp_pkg::mag_t'(dy_q[i]);
      lx_q[i]   <= dx_q[i] * dx_q[i];
      ly_q[i]   <= dy_q[i] * dy_q[i];
      len2_q[i] <= tnp_pkg::len2_t'(tnp_pkg::sum_t'(lx_q[i]) + tnp_pkg::sum_t'(ly_q[i]));
    end
    cp1_q <= dy_q[0] * dx_q[2];
    cp2_q <= dx_q[0] * dy_q[2];
    c_q   <= tnp_pkg::sum_t'(cp1_q) - tnp_pkg::sum_t'(cp2_q);
  end

  // pipeline control
  assign en       = !m_valid_q || m_tready;
  assign s_tready = en;
  assign q_in.x   = s_tdata[15:0];
  assign q_in.y   = s_tdata[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[tnp_pkg::NumStages-2:0], s_tvalid};
      m_valid_q <= vld_q[tnp_pkg::NumStages-1];
    end
  end

  // containment test and edge classification
  always_comb begin
    rr = tnp_pkg::cross_t'(c_q) - tnp_pkg::cross_t'(a3_q) - tnp_pkg::cross_t'(b3_q);
    side4_d.q   = q3_q;
    side4_d.dv0 = dv3_q;
    priority if (c_q > 0) begin
      side4_d.in_tri = (a3_q >= 0) && (b3_q >= 0) && (rr >= 0);
    end else if (c_q < 0) begin
      side4_d.in_tri = (a3_q <= 0) && (b3_q <= 0) && (rr <= 0);
    end else begin
      side4_d.in_tri = 1'b0;
    end
    for (int i = 0; i < NV; i++) begin
      len2s[i]        = tnp_pkg::sum_t'({1'b0, len2_q[i]});
      side4_d.skip[i] = (len2_q[i] == '0);
      side4_d.lo[i]   = (k3_q[i] <= 0);
      side4_d.hi[i]   = (k3_q[i] >= len2s[i]);
      kdiv_d[i]       = (!side4_d.lo[i] && !side4_d.hi[i]) ? tnp_pkg::len2_t'(k3_q[i]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q <= q_in;
      for (int i = 0; i < NV; i++) begin
        w1x_q[i] <= tnp_pkg::diff_t'(q_in.x) - tnp_pkg::diff_t'(vx_q[i]);
        w1y_q[i] <= tnp_pkg::diff_t'(q_in.y) - tnp_pkg::diff_t'(vy_q[i]);
      end

      q2_q  <= q1_q;
      ap1_q <= w1y_q[0] * dx_q[2];
      ap2_q <= w1x_q[0] * dy_q[2];
      bp1_q <= dx_q[0] * w1y_q[0];
      bp2_q <= dy_q[0] * w1x_q[0];
      vx2_q <= w1x_q[0] * w1x_q[0];
      vy2_q <= w1y_q[0] * w1y_q[0];
      for (int i = 0; i < NV; i++) begin
        kx_q[i] <= w1x_q[i] * dx_q[i];
        ky_q[i] <= w1y_q[i] * dy_q[i];
      end

      q3_q  <= q2_q;
      a3_q  <= tnp_pkg::sum_t'(ap1_q) - tnp_pkg::sum_t'(ap2_q);
      b3_q  <= tnp_pkg::sum_t'(bp1_q) - tnp_pkg::sum_t'(bp2_q);
      dv3_q <= tnp_pkg::len2_t'(tnp_pkg::sum_t'(vx2_q) + tnp_pkg::sum_t'(vy2_q));
      for (int i = 0; i < NV; i++) begin
        k3_q[i] <= tnp_pkg::sum_t'(kx_q[i]) + tnp_pkg::sum_t'(ky_q[i]);
      end

      side4_q <= side4_d;
      for (int i = 0; i < NV; i++) begin
        kdiv_q[i] <= kdiv_d[i];
      end

      side_dl_q[0] <= side4_q;
      for (int s = 1; s < tnp_pkg::DivLat; s++) begin
        side_dl_q[s] <= side_dl_q[s-1];
      end
    end
  end

  for (genvar i = 0; i < NV; i++) begin : g_div
    tnp_div u_div_x (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (kdiv_q[i]),
      .den_i  (len2_q[i]),
      .mag_i  (magx_q[i]),
      .quot_o (quotx[i])
    );
    tnp_div u_div_y (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (kdiv_q[i]),
      .den_i  (len2_q[i]),
      .mag_i  (magy_q[i]),
      .quot_o (quoty[i])
    );
  end

  // edge candidates
  always_comb begin
    side_r = side_dl_q[tnp_pkg::DivLat-1];
    offx   = '0;
    offy   = '0;
    for (int i = 0; i < NV; i++) begin
      offx = dx_q[i][tnp_pkg::DiffW-1] ? -tnp_pkg::diff_t'({1'b0, quotx[i]})
                                       :  tnp_pkg::diff_t'({1'b0, quotx[i]});
      offy = dy_q[i][tnp_pkg::DiffW-1] ? -tnp_pkg::diff_t'({1'b0, quoty[i]})
                                       :  tnp_pkg::diff_t'({1'b0, quoty[i]});
      priority if (side_r.lo[i]) begin
        cand_r[i].x = vx_q[i];
        cand_r[i].y = vy_q[i];
      end else if (side_r.hi[i]) begin
        cand_r[i].x = vx_q[(i == NV-1) ? 0 : i+1];
        cand_r[i].y = vy_q[(i == NV-1) ? 0 : i+1];
      end else begin
        cand_r[i].x = tnp_pkg::coord_t'(tnp_pkg::diff_t'(vx_q[i]) + offx);
        cand_r[i].y = tnp_pkg::coord_t'(tnp_pkg::diff_t'(vy_q[i]) + offy);
      end
      quot_ok[i] = !(vld_q[tnp_pkg::StgR] && !side_r.lo[i] && !side_r.hi[i] &&
                     !side_r.skip[i]) ||
                   ((quotx[i] <= magx_q[i]) && (quoty[i] <= magy_q[i]));
    end
  end

  assign best_init.pt.x = vx_q[0];
  assign best_init.pt.y = vy_q[0];
  assign best_init.d    = side_p_q[3].dv0;

  // distances and selection
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_p_q[0] <= side_r;
      for (int i = 0; i < NV; i++) begin
        cand_q[0][i] <= cand_r[i];
      end
      for (int s = 1; s < 7; s++) begin
        side_p_q[s] <= side_p_q[s-1];
        for (int i = 0; i < NV; i++) begin
          cand_q[s][i] <= cand_q[s-1][i];
        end
      end
      for (int i = 0; i < NV; i++) begin
        ex_q[i]    <= tnp_pkg::diff_t'(side_p_q[0].q.x) - tnp_pkg::diff_t'(cand_q[0][i].x);
        ey_q[i]    <= tnp_pkg::diff_t'(side_p_q[0].q.y) - tnp_pkg::diff_t'(cand_q[0][i].y);
        sx_q[i]    <= ex_q[i] * ex_q[i];
        sy_q[i]    <= ey_q[i] * ey_q[i];
        dd_q[0][i] <= tnp_pkg::len2_t'(tnp_pkg::sum_t'(sx_q[i]) + tnp_pkg::sum_t'(sy_q[i]));
        dd_q[1][i] <= dd_q[0][i];
        dd_q[2][i] <= dd_q[1][i];
      end
      best_q[0] <= tnp_pkg::pick_best(best_init, cand_q[3][0], dd_q[0][0],
                                      side_p_q[3].skip[0]);
      best_q[1] <= tnp_pkg::pick_best(best_q[0], cand_q[4][1], dd_q[1][1],
                                      side_p_q[4].skip[1]);
      best_q[2] <= tnp_pkg::pick_best(best_q[1], cand_q[5][2], dd_q[2][2],
                                      side_p_q[5].skip[2]);
      out_q    <= side_p_q[6].in_tri ? side_p_q[6].q : best_q[2].pt;
      out_in_q <= side_p_q[6].in_tri;
    end
  end

  assign m_tvalid   = m_valid_q;
  assign m_tdata    = {out_q.y, out_q.x};
  assign m_tuser[0] = out_in_q;

  `ASSERT_DEF(a_stall_holds, !en |=> $stable(vld_q), "pipeline advanced during stall")
  `ASSERT_DEF(a_no_phantom, (!(|vld_q) && !m_valid_q) |=> !m_valid_q, "result from empty pipe")
  `ASSERT_DEF(a_quot_bound, &quot_ok, "edge quotient beyond edge length")
  `ASSERT_DEF(a_in_tri_area, (vld_q[tnp_pkg::StgA4] && side4_q.in_tri) |-> (c_q != 0), "in_tri on flat triangle")

endmodule

// ----- verif/tnp_checker.sv -----
module tnp_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tnp_pkg::AddrW-1:0] paddr,
  input  logic [tnp_pkg::DataW-1:0] pwdata,
  input  logic                      pready,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [31:0]               s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [31:0]               m_tdata,
  input  logic [0:0]                m_tuser,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tnp_pkg::coord_t x;
    tnp_pkg::coord_t y;
    logic            was_in;
  } nearest_t;

  tnp_pkg::coord_t corner_q [6];
  nearest_t        nearest_q [$];

  function automatic longint rnd_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (2 * mag + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic nearest_t nearest_point(tnp_pkg::coord_t qx_i, tnp_pkg::coord_t qy_i);
    longint vx [3];
    longint vy [3];
    longint qx, qy, e0x, e0y, e1x, e1y, wx, wy, c, a, b, r;
    longint bx, by, bd, sx, sy, dx, dy, len2, k, cx, cy, dd;
    logic in_tri;
    int j;
    nearest_t res;
    qx = qx_i;
    qy = qy_i;
    for (int i = 0; i < 3; i++) begin
      vx[i] = corner_q[2*i];
      vy[i] = corner_q[2*i+1];
    end
    e0x = vx[1] - vx[0]; e0y = vy[1] - vy[0];
    e1x = vx[2] - vx[0]; e1y = vy[2] - vy[0];
    wx = qx - vx[0];     wy = qy - vy[0];
    c = e0x * e1y - e0y * e1x;
    a = wx * e1y - wy * e1x;
    b = e0x * wy - e0y * wx;
    r = c - a - b;
    in_tri = 1'b0;
    if (c > 0) in_tri = (a >= 0) && (b >= 0) && (r >= 0);
    else if (c < 0) in_tri = (a <= 0) && (b <= 0) && (r <= 0);
    if (in_tri) begin
      res.x = qx_i;
      res.y = qy_i;
      res.was_in = 1'b1;
      return res;
    end
    bx = vx[0];
    by = vy[0];
    bd = (qx - bx) * (qx - bx) + (qy - by) * (qy - by);
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      sx = vx[i]; sy = vy[i];
      dx = vx[j] - sx; dy = vy[j] - sy;
      len2 = dx * dx + dy * dy;
      if (len2 != 0) begin
        k = (qx - sx) * dx + (qy - sy) * dy;
        if (k <= 0) begin
          cx = sx; cy = sy;
        end else if (k >= len2) begin
          cx = vx[j]; cy = vy[j];
        end else begin
          cx = sx + rnd_div(dx * k, len2);
          cy = sy + rnd_div(dy * k, len2);
        end
        dd = (qx - cx) * (qx - cx) + (qy - cy) * (qy - cy);
        if (dd < bd) begin
          bd = dd; bx = cx; by = cy;
        end
      end
    end
    res.x = tnp_pkg::coord_t'(bx);
    res.y = tnp_pkg::coord_t'(by);
    res.was_in = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t want;
    tnp_pkg::coord_t got_x, got_y;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) corner_q[i] = '0;
      nearest_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 && paddr[4:2] < 6)
        corner_q[paddr[4:2]] = pwdata[15:0];
      if (s_tvalid && s_tready)
        nearest_q.push_back(nearest_point(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        got_x = m_tdata[15:0];
        got_y = m_tdata[31:16];
        if (nearest_q.size() == 0) begin
          $display("%t: unexpected result x=%0d y=%0d inside=%0b",
                   $realtime, got_x, got_y, m_tuser[0]);
          errors++;
        end else begin
          want = nearest_q.pop_front();
          if (got_x !== want.x || got_y !== want.y || m_tuser[0] !== want.was_in) begin
            $display("%t: mismatch expected x=%0d y=%0d inside=%0b, got x=%0d y=%0d inside=%0b",
                     $realtime, want.x, want.y, want.was_in, got_x, got_y, m_tuser[0]);
            errors++;
          end
        end
      end
      pending = nearest_q.size();
    end
  end
endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 3000;

  logic                          clk_i, rst_ni;
  logic                          psel, penable, pwrite, pready;
  logic [tnp_pkg::AddrW-1:0]     paddr;
  logic [tnp_pkg::DataW-1:0]     pwdata, prdata;
  logic                          s_tvalid, s_tready, m_tvalid, m_tready;
  logic [31:0]                   s_tdata, m_tdata;
  logic [0:0]                    m_tuser;
  int                            errors, pending;
  int                            burst_left;
  int                            idle_cycles;
  bit                            hold_req;

  triangle_nearest_point DUT (.*);

  tnp_checker u_checker (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // receiver: stall pattern changes at random among four modes, plus one long hold-off
  initial begin
    int mode;
    bit held;
    m_tready = 1'b0;
    mode = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        held = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL triangle_nearest_point");
      $finish;
    end
  end

  task automatic reg_write(tnp_pkg::reg_idx_e idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tnp_pkg::AddrW'(4 * int'(idx));
    pwdata  <= {16'h0, 16'(val)};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (35) @(negedge clk_i);
  endtask

  task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
    drain();
    reg_write(tnp_pkg::REG_V0X, x0);
    reg_write(tnp_pkg::REG_V0Y, y0);
    reg_write(tnp_pkg::REG_V1X, x1);
    reg_write(tnp_pkg::REG_V1Y, y1);
    reg_write(tnp_pkg::REG_V2X, x2);
    reg_write(tnp_pkg::REG_V2Y, y2);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic send_query(int qx, int qy);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {16'(qy), 16'(qx)};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  initial begin
    int cx, cy, sz, vx [3], vy [3];
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    hold_req = 1'b0;
    burst_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all corners at zero after reset
    send_query(100, -50);
    send_query(0, 0);

    set_triangle(0, 0, 1600, 0, 0, 1600);
    send_query(160, 160);
    send_query(0, 0);
    send_query(800, 800);
    send_query(800, -300);
    send_query(-300, 800);
    send_query(2000, 2000);
    send_query(-500, -500);
    send_query(3000, -10);
    send_query(-32768, -32768);
    send_query(32767, 32767);
    send_query(32767, -32768);

    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_query(32767, 32767);
    send_query(-32768, 32767);
    send_query(0, 0);

    // clockwise winding
    set_triangle(0, 0, 0, 1600, 1600, 0);
    send_query(100, 100);
    send_query(-100, 900);

    // collinear corners
    set_triangle(0, 0, 100, 100, 200, 200);
    send_query(100, 100);
    send_query(0, 300);

    // two corners equal
    set_triangle(50, 50, 50, 50, 900, -400);
    send_query(500, 500);

    // all corners equal
    set_triangle(5, 5, 5, 5, 5, 5);
    send_query(-32768, 32767);

    for (int ph = 0; ph < 8; ph++) begin
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      case ($urandom_range(0, 3))
        0: sz = $urandom_range(1, 64);
        1, 2: sz = $urandom_range(64, 3000);
        default: sz = $urandom_range(3000, 32767);
      endcase
      for (int i = 0; i < 3; i++) begin
        vx[i] = clamp16(cx + $urandom_range(0, 2 * sz) - sz);
        vy[i] = clamp16(cy + $urandom_range(0, 2 * sz) - sz);
      end
      if (ph == 3) begin
        vx[2] = vx[0] + (vx[1] - vx[0]) / 2;
        vy[2] = vy[0] + (vy[1] - vy[0]) / 2;
      end
      set_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(0, 9) < 6)
          send_query(clamp16(cx + $urandom_range(0, 4 * sz) - 2 * sz),
                     clamp16(cy + $urandom_range(0, 4 * sz) - 2 * sz));
        else
          send_query($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
      end
    end

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("PASS triangle_nearest_point");
    else
      $display("FAIL triangle_nearest_point");
    $finish;
  end
endmodule
